/* src/dtp_pkg.sv */
// Shared types and constants of the DHCPv6 option TLV parser.
package dtp_pkg;

    localparam int IA_FIXED_BYTES   = 12;
    localparam int ADDR_FIXED_BYTES = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_IA_NA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_IA_PD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_IA_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPT_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPTS     = 3'd4;

    typedef enum logic [2:0] {
        PH_MSG_HDR,
        PH_OPT_HDR,
        PH_FIX_IA,
        PH_FIX_ADDR,
        PH_DATA,
        PH_SKIP,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_OPT,
        KIND_PAY,
        KIND_END
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TRUNC,
        ST_TOO_LONG,
        ST_SHORT,
        ST_DEEP
    } t_status;

    typedef struct packed {
        logic [15:0] code_ia_na;
        logic [15:0] code_ia_pd;
        logic [15:0] code_ia_addr;
        logic [15:0] max_len;
        logic [7:0]  max_opts;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  mtype;
        logic [23:0] tid;
        logic [15:0] code;
        logic [15:0] len;
        logic [1:0]  lvl;
        logic [7:0]  pbyte;
        logic [15:0] off;
    } t_rec;

    typedef struct packed {
        logic    first_valid;
        t_rec    first;
        logic    stat_valid;
        t_status status;
    } t_entry;

endpackage

/* src/dtp_parser.sv */
// Front part: parses message bytes and produces the record entry of each byte that yields one.
module dtp_parser #(
    parameter int MAX_LEVELS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtp_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_wr,
    output dtp_pkg::t_entry   o_entry
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    dtp_pkg::t_phase  r_phase, n_phase;
    logic [15:0]      r_cnt, n_cnt;
    logic [31:0]      r_shift, n_shift;
    logic [15:0]      r_code, n_code;
    logic [15:0]      r_len, n_len;
    logic [LW-1:0]    r_lvl, n_lvl;
    dtp_pkg::t_status r_err, n_err;
    logic [15:0]      r_rem  [MAX_LEVELS];
    logic [15:0]      n_rem  [MAX_LEVELS];
    logic [7:0]       r_ocnt [MAX_LEVELS];
    logic [7:0]       n_ocnt [MAX_LEVELS];

    always_comb begin
        logic        skip;
        logic        is_ia;
        logic        is_addr;
        logic [15:0] fixed;
        logic [15:0] target;
        logic        do_finish;
        logic        do_close;
        logic [15:0] code_w;
        logic [15:0] len_w;

        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_code    = r_code;
        n_len     = r_len;
        n_lvl     = r_lvl;
        n_err     = r_err;
        n_rem     = r_rem;
        n_ocnt    = r_ocnt;
        o_entry   = '0;
        skip      = 1'b0;
        is_ia     = 1'b0;
        is_addr   = 1'b0;
        fixed     = '0;
        target    = '0;
        do_finish = 1'b0;
        do_close  = 1'b0;
        code_w    = '0;
        len_w     = '0;

        if (i_accept) begin
            if (r_phase != dtp_pkg::PH_MSG_HDR && r_phase != dtp_pkg::PH_ERROR) begin
                for (int l = 1; l < MAX_LEVELS; l++) begin
                    if (l <= int'(r_lvl) && r_rem[l] != 16'd0) begin
                        n_rem[l] = r_rem[l] - 16'd1;
                    end
                end
            end

            case (r_phase)
                dtp_pkg::PH_MSG_HDR: begin
                    n_shift = {r_shift[23:0], i_data_byte};
                    n_cnt   = r_cnt + 16'd1;
                    if (n_cnt >= 16'd4) begin
                        o_entry.first_valid = 1'b1;
                        o_entry.first.kind  = dtp_pkg::KIND_HDR;
                        o_entry.first.mtype = n_shift[31:24];
                        o_entry.first.tid   = n_shift[23:0];
                        n_phase   = dtp_pkg::PH_OPT_HDR;
                        n_cnt     = '0;
                        n_shift   = '0;
                        n_lvl     = '0;
                        n_ocnt[0] = '0;
                    end
                end
                dtp_pkg::PH_OPT_HDR, dtp_pkg::PH_SKIP: begin
                    skip = (r_phase == dtp_pkg::PH_SKIP) ||
                           (r_cnt == 16'd0 && r_ocnt[r_lvl] >= i_cfg.max_opts);
                    if (skip) begin
                        n_phase = dtp_pkg::PH_SKIP;
                        if (r_lvl != '0 && n_rem[r_lvl] == 16'd0) begin
                            do_close = 1'b1;
                        end
                    end else begin
                        n_shift = {r_shift[23:0], i_data_byte};
                        n_cnt   = r_cnt + 16'd1;
                        if (n_cnt >= 16'd4) begin
                            code_w  = n_shift[31:16];
                            len_w   = n_shift[15:0];
                            n_code  = code_w;
                            n_len   = len_w;
                            is_ia   = (code_w == i_cfg.code_ia_na) ||
                                      (code_w == i_cfg.code_ia_pd);
                            is_addr = !is_ia && (code_w == i_cfg.code_ia_addr);
                            fixed   = is_ia   ? 16'(dtp_pkg::IA_FIXED_BYTES) :
                                      is_addr ? 16'(dtp_pkg::ADDR_FIXED_BYTES) : 16'd0;
                            if (len_w > i_cfg.max_len) begin
                                n_err   = dtp_pkg::ST_TOO_LONG;
                                n_phase = dtp_pkg::PH_ERROR;
                            end else if (fixed != 16'd0 && len_w < fixed) begin
                                n_err   = dtp_pkg::ST_SHORT;
                                n_phase = dtp_pkg::PH_ERROR;
                            end else if (r_lvl != '0 && len_w > n_rem[r_lvl]) begin
                                n_err   = dtp_pkg::ST_TRUNC;
                                n_phase = dtp_pkg::PH_ERROR;
                            end else if (fixed != 16'd0 && len_w > fixed &&
                                         int'(r_lvl) + 1 >= MAX_LEVELS) begin
                                n_err   = dtp_pkg::ST_DEEP;
                                n_phase = dtp_pkg::PH_ERROR;
                            end else begin
                                o_entry.first_valid = 1'b1;
                                o_entry.first.kind  = dtp_pkg::KIND_OPT;
                                o_entry.first.code  = code_w;
                                o_entry.first.len   = len_w;
                                o_entry.first.lvl   = 2'(r_lvl);
                                n_cnt   = '0;
                                n_phase = is_ia   ? dtp_pkg::PH_FIX_IA :
                                          is_addr ? dtp_pkg::PH_FIX_ADDR : dtp_pkg::PH_DATA;
                                if (len_w == 16'd0) begin
                                    do_finish = 1'b1;
                                end
                            end
                        end else if (r_lvl != '0 && n_rem[r_lvl] == 16'd0) begin
                            n_err   = dtp_pkg::ST_TRUNC;
                            n_phase = dtp_pkg::PH_ERROR;
                        end
                    end
                end
                dtp_pkg::PH_FIX_IA, dtp_pkg::PH_FIX_ADDR, dtp_pkg::PH_DATA: begin
                    o_entry.first_valid = 1'b1;
                    o_entry.first.kind  = dtp_pkg::KIND_PAY;
                    o_entry.first.code  = r_code;
                    o_entry.first.len   = r_len;
                    o_entry.first.lvl   = 2'(r_lvl);
                    o_entry.first.pbyte = i_data_byte;
                    o_entry.first.off   = r_cnt;
                    n_cnt  = r_cnt + 16'd1;
                    target = (r_phase == dtp_pkg::PH_FIX_IA) ?
                             16'(dtp_pkg::IA_FIXED_BYTES) : 16'(dtp_pkg::ADDR_FIXED_BYTES);
                    if (r_phase == dtp_pkg::PH_DATA) begin
                        if (n_cnt >= r_len) begin
                            do_finish = 1'b1;
                        end
                    end else if (n_cnt >= target) begin
                        if (r_len <= target) begin
                            do_finish = 1'b1;
                        end else if (int'(r_lvl) + 1 >= MAX_LEVELS) begin
                            n_err   = dtp_pkg::ST_DEEP;
                            n_phase = dtp_pkg::PH_ERROR;
                        end else begin
                            for (int l = 1; l < MAX_LEVELS; l++) begin
                                if (l == int'(r_lvl) + 1) begin
                                    n_rem[l]  = r_len - target;
                                    n_ocnt[l] = '0;
                                end
                            end
                            n_lvl   = LW'(int'(r_lvl) + 1);
                            n_phase = dtp_pkg::PH_OPT_HDR;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (do_finish) begin
                for (int l = 0; l < MAX_LEVELS; l++) begin
                    if (l == int'(n_lvl) && n_ocnt[l] != 8'hFF) begin
                        n_ocnt[l] = n_ocnt[l] + 8'd1;
                    end
                end
            end
            if (do_finish || do_close) begin
                for (int l = MAX_LEVELS - 1; l >= 1; l--) begin
                    if (int'(n_lvl) == l && n_rem[l] == 16'd0) begin
                        n_lvl = LW'(l - 1);
                        if (n_ocnt[l-1] != 8'hFF) begin
                            n_ocnt[l-1] = n_ocnt[l-1] + 8'd1;
                        end
                    end
                end
                n_phase = dtp_pkg::PH_OPT_HDR;
                n_cnt   = '0;
                n_shift = '0;
            end

            if (i_last_byte) begin
                o_entry.stat_valid = 1'b1;
                if (n_err != dtp_pkg::ST_OK) begin
                    o_entry.status = n_err;
                end else if (n_phase == dtp_pkg::PH_MSG_HDR || n_lvl != '0 ||
                             n_phase == dtp_pkg::PH_FIX_IA ||
                             n_phase == dtp_pkg::PH_FIX_ADDR ||
                             n_phase == dtp_pkg::PH_DATA ||
                             (n_phase == dtp_pkg::PH_OPT_HDR && n_cnt != 16'd0)) begin
                    o_entry.status = dtp_pkg::ST_TRUNC;
                end else begin
                    o_entry.status = dtp_pkg::ST_OK;
                end
                n_phase = dtp_pkg::PH_MSG_HDR;
                n_cnt   = '0;
                n_shift = '0;
                n_code  = '0;
                n_len   = '0;
                n_lvl   = '0;
                n_err   = dtp_pkg::ST_OK;
                for (int l = 0; l < MAX_LEVELS; l++) begin
                    n_rem[l]  = '0;
                    n_ocnt[l] = '0;
                end
            end
        end
    end

    assign o_wr = i_accept && (o_entry.first_valid || o_entry.stat_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtp_pkg::PH_MSG_HDR;
            r_cnt   <= '0;
            r_shift <= '0;
            r_code  <= '0;
            r_len   <= '0;
            r_lvl   <= '0;
            r_err   <= dtp_pkg::ST_OK;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_rem[l]  <= '0;
                r_ocnt[l] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_code  <= n_code;
            r_len   <= n_len;
            r_lvl   <= n_lvl;
            r_err   <= n_err;
            r_rem   <= n_rem;
            r_ocnt  <= n_ocnt;
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lvl) < MAX_LEVELS)
        else $error("Nesting level beyond the level limit.");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dtp_pkg::PH_ERROR) |-> (r_err != dtp_pkg::ST_OK))
        else $error("Error phase without an error code.");

    a_data_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dtp_pkg::PH_DATA) |-> (r_cnt < r_len))
        else $error("Opaque data offset past the option length.");

endmodule

/* src/dtp_fifo.sv */
// Short queue of record entries between the parser and the result side.
module dtp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  dtp_pkg::t_entry i_entry,
    input  logic            i_rd,
    output dtp_pkg::t_entry o_entry,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = $clog2(dtp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(dtp_pkg::QUEUE_DEPTH + 1);

    dtp_pkg::t_entry r_mem [dtp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr_go, rd_go;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(dtp_pkg::QUEUE_DEPTH));
    assign wr_go   = i_wr && !o_full;
    assign rd_go   = i_rd && !o_empty;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_go) begin
                r_wp <= (r_wp == PW'(dtp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_go) begin
                r_rp <= (r_rp == PW'(dtp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(dtp_pkg::QUEUE_DEPTH))
        else $error("Entry queue holds more than its depth.");

endmodule

/* src/dtp_emitter.sv */
// Back part: splits each queued entry into result beats.
module dtp_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtp_pkg::t_entry  i_entry,
    input  logic             i_empty,
    input  logic             i_pop,
    output logic             o_rd,
    output dtp_pkg::t_rec    o_rec,
    output dtp_pkg::t_status o_status,
    output logic             o_last
);

    logic          r_half;
    logic          show_first;
    logic          beat;
    dtp_pkg::t_rec end_rec;

    always_comb begin
        end_rec      = '0;
        end_rec.kind = dtp_pkg::KIND_END;
    end

    assign show_first = i_entry.first_valid && !r_half;
    assign o_rec      = show_first ? i_entry.first : end_rec;
    assign o_status   = show_first ? dtp_pkg::ST_OK : i_entry.status;
    assign o_last     = show_first ? !i_entry.stat_valid : 1'b1;
    assign beat       = i_pop && !i_empty;
    assign o_rd       = beat && (!show_first || !i_entry.stat_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (beat) begin
            r_half <= show_first && i_entry.stat_valid;
        end
    end

    a_half_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (!i_empty && i_entry.first_valid && i_entry.stat_valid))
        else $error("Second beat pending without a two-result entry.");

    a_split_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && show_first && i_entry.stat_valid) |=> (r_half && o_last))
        else $error("Status beat of a two-result entry was lost.");

endmodule

/* src/dhcpv6_option_tlv_parser.sv */
// Top level of the DHCPv6 option TLV parser: configuration, parser, queue and result side.
// The results of a byte are registered in the queue when the byte is accepted.
// Throughput: one byte per cycle; the parser takes a byte in every cycle the queue is not full.
// A final byte that also yields a record gives two results and holds its entry two beats.
// Reset is synchronous and active low: parse state clears, the queue empties, registers reload.
module dhcpv6_option_tlv_parser #(
    parameter int MAX_LEVELS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_record_kind,
    output logic [7:0]                    o_message_type,
    output logic [23:0]                   o_transaction_id,
    output logic [15:0]                   o_option_code,
    output logic [15:0]                   o_option_length,
    output logic [1:0]                    o_nest_level,
    output logic [7:0]                    o_payload_byte,
    output logic [15:0]                   o_payload_offset,
    output logic [2:0]                    o_parse_status,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_we,
    input  logic [dtp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    dtp_pkg::t_cfg    r_cfg;
    dtp_pkg::t_entry  wr_entry, rd_entry;
    dtp_pkg::t_rec    rec;
    dtp_pkg::t_status status;
    logic             accept, wr, rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_ia_na   <= 16'd3;
            r_cfg.code_ia_pd   <= 16'd25;
            r_cfg.code_ia_addr <= 16'd5;
            r_cfg.max_len      <= 16'd512;
            r_cfg.max_opts     <= 8'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dtp_pkg::CFG_CODE_IA_NA:   r_cfg.code_ia_na   <= i_cfg_data;
                dtp_pkg::CFG_CODE_IA_PD:   r_cfg.code_ia_pd   <= i_cfg_data;
                dtp_pkg::CFG_CODE_IA_ADDR: r_cfg.code_ia_addr <= i_cfg_data;
                dtp_pkg::CFG_MAX_OPT_LEN:  r_cfg.max_len      <= i_cfg_data;
                dtp_pkg::CFG_MAX_OPTS:     r_cfg.max_opts     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    dtp_parser #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (wr),
        .o_entry     (wr_entry)
    );

    dtp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_entry (wr_entry),
        .i_rd    (rd),
        .o_entry (rd_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    dtp_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (rd_entry),
        .i_empty  (empty),
        .i_pop    (pop),
        .o_rd     (rd),
        .o_rec    (rec),
        .o_status (status),
        .o_last   (o_last_of_run)
    );

    assign o_record_kind    = rec.kind;
    assign o_message_type   = rec.mtype;
    assign o_transaction_id = rec.tid;
    assign o_option_code    = rec.code;
    assign o_option_length  = rec.len;
    assign o_nest_level     = rec.lvl;
    assign o_payload_byte   = rec.pbyte;
    assign o_payload_offset = rec.off;
    assign o_parse_status   = status;

endmodule

/* tb/sv/dhcpv6_option_tlv_parser_checker.sv */
`timescale 1ns / 100ps
// Checker of the DHCPv6 option TLV parser: predicts the records of each byte and checks each beat.
module dhcpv6_option_tlv_parser_checker
    import dtp_pkg::*;
#(
    parameter int MAX_LEVELS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [1:0]           i_record_kind,
    input  logic [7:0]           i_message_type,
    input  logic [23:0]          i_transaction_id,
    input  logic [15:0]          i_option_code,
    input  logic [15:0]          i_option_length,
    input  logic [1:0]           i_nest_level,
    input  logic [7:0]           i_payload_byte,
    input  logic [15:0]          i_payload_offset,
    input  logic [2:0]           i_parse_status,
    input  logic                 i_last_of_run,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam logic [15:0] DEF_CODE_IA_NA   = 16'd3;
    localparam logic [15:0] DEF_CODE_IA_PD   = 16'd25;
    localparam logic [15:0] DEF_CODE_IA_ADDR = 16'd5;
    localparam logic [15:0] DEF_MAX_LEN      = 16'd512;
    localparam logic [7:0]  DEF_MAX_OPTS     = 8'd64;
    localparam int          REPORT_LIMIT     = 10;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  mtype;
        logic [23:0] tid;
        logic [15:0] code;
        logic [15:0] len;
        logic [1:0]  lvl;
        logic [7:0]  pbyte;
        logic [15:0] off;
        t_status     status;
        logic        is_last;
    } t_parse_rec;

    t_cfg        cfg;
    t_phase      phase;
    logic [15:0] byte_cnt;
    logic [31:0] hdr_shift;
    logic [15:0] cur_code;
    logic [15:0] cur_len;
    int          cur_lvl;
    logic [15:0] lvl_left [MAX_LEVELS];
    logic [7:0]  lvl_count [MAX_LEVELS];
    t_status     err;

    t_parse_rec  beat_recs [2];
    int          beat_n;
    t_parse_rec  parsed_records [$];
    t_parse_rec  seen;
    t_parse_rec  want;
    int          fail_count = 0;
    int          checked = 0;

    task automatic start_message();
        phase     = PH_MSG_HDR;
        byte_cnt  = '0;
        hdr_shift = '0;
        cur_code  = '0;
        cur_len   = '0;
        cur_lvl   = 0;
        err       = ST_OK;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            lvl_left[l]  = '0;
            lvl_count[l] = '0;
        end
    endtask

    task automatic add_record(input t_kind kind, input logic [7:0] mtype,
                              input logic [23:0] tid, input logic [7:0] pb,
                              input logic [15:0] off, input t_status st);
        t_parse_rec r;
        if (beat_n >= 2) return;
        r        = '0;
        r.kind   = kind;
        r.mtype  = mtype;
        r.tid    = tid;
        if (kind == KIND_OPT || kind == KIND_PAY) begin
            r.code = cur_code;
            r.len  = cur_len;
            r.lvl  = 2'(cur_lvl);
        end
        r.pbyte  = pb;
        r.off    = off;
        r.status = st;
        beat_recs[beat_n] = r;
        beat_n++;
    endtask

    task automatic consume_budget();
        for (int l = 1; l <= cur_lvl && l < MAX_LEVELS; l++) begin
            if (lvl_left[l] != 16'd0) lvl_left[l] = lvl_left[l] - 16'd1;
        end
    endtask

    task automatic count_option();
        if (cur_lvl < MAX_LEVELS && lvl_count[cur_lvl] != 8'hFF)
            lvl_count[cur_lvl] = lvl_count[cur_lvl] + 8'd1;
    endtask

    task automatic close_lists();
        while (cur_lvl >= 1 && cur_lvl < MAX_LEVELS && lvl_left[cur_lvl] == 16'd0) begin
            cur_lvl--;
            count_option();
        end
        phase     = PH_OPT_HDR;
        byte_cnt  = '0;
        hdr_shift = '0;
    endtask

    task automatic finish_option();
        count_option();
        close_lists();
    endtask

    task automatic raise_error(input t_status st);
        err   = st;
        phase = PH_ERROR;
    endtask

    task automatic option_header_done();
        int fixed_len;
        fixed_len = 0;
        cur_code  = hdr_shift[31:16];
        cur_len   = hdr_shift[15:0];
        if (cur_code == cfg.code_ia_na || cur_code == cfg.code_ia_pd)
            fixed_len = IA_FIXED_BYTES;
        else if (cur_code == cfg.code_ia_addr)
            fixed_len = ADDR_FIXED_BYTES;
        if (cur_len > cfg.max_len) begin
            raise_error(ST_TOO_LONG);
            return;
        end
        if (fixed_len != 0 && int'(cur_len) < fixed_len) begin
            raise_error(ST_SHORT);
            return;
        end
        if (cur_lvl >= 1 && cur_lvl < MAX_LEVELS && cur_len > lvl_left[cur_lvl]) begin
            raise_error(ST_TRUNC);
            return;
        end
        if (fixed_len != 0 && int'(cur_len) > fixed_len && cur_lvl + 1 >= MAX_LEVELS) begin
            raise_error(ST_DEEP);
            return;
        end
        add_record(KIND_OPT, '0, '0, '0, '0, ST_OK);
        byte_cnt = '0;
        if (fixed_len == IA_FIXED_BYTES) begin
            phase = PH_FIX_IA;
        end else if (fixed_len == ADDR_FIXED_BYTES) begin
            phase = PH_FIX_ADDR;
        end else begin
            phase = PH_DATA;
        end
        if (cur_len == 16'd0) finish_option();
    endtask

    task automatic take_payload_byte(input logic [7:0] b);
        int goal;
        int nl;
        add_record(KIND_PAY, '0, '0, b, byte_cnt, ST_OK);
        consume_budget();
        byte_cnt = byte_cnt + 16'd1;
        if (phase == PH_DATA) begin
            if (byte_cnt >= cur_len) finish_option();
            return;
        end
        goal = (phase == PH_FIX_IA) ? IA_FIXED_BYTES : ADDR_FIXED_BYTES;
        if (int'(byte_cnt) < goal) return;
        if (int'(cur_len) <= goal) begin
            finish_option();
            return;
        end
        nl = cur_lvl + 1;
        if (nl >= MAX_LEVELS) begin
            raise_error(ST_DEEP);
            return;
        end
        lvl_left[nl]  = cur_len - 16'(goal);
        lvl_count[nl] = '0;
        cur_lvl       = nl;
        phase         = PH_OPT_HDR;
        byte_cnt      = '0;
        hdr_shift     = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        int      lvl;
        t_status st;
        beat_n = 0;
        lvl    = cur_lvl;
        if (lvl >= MAX_LEVELS) begin
            raise_error(ST_TRUNC);
            lvl = 0;
        end
        case (phase)
            PH_MSG_HDR: begin
                hdr_shift = {hdr_shift[23:0], b};
                byte_cnt  = byte_cnt + 16'd1;
                if (byte_cnt >= 16'd4) begin
                    add_record(KIND_HDR, hdr_shift[31:24], hdr_shift[23:0], '0, '0, ST_OK);
                    phase        = PH_OPT_HDR;
                    byte_cnt     = '0;
                    hdr_shift    = '0;
                    cur_lvl      = 0;
                    lvl_count[0] = '0;
                end
            end
            PH_OPT_HDR, PH_SKIP: begin
                if (phase == PH_OPT_HDR && byte_cnt == 16'd0 && lvl_count[lvl] >= cfg.max_opts)
                    phase = PH_SKIP;
                if (phase == PH_SKIP) begin
                    consume_budget();
                    if (lvl >= 1 && lvl_left[lvl] == 16'd0) close_lists();
                end else begin
                    hdr_shift = {hdr_shift[23:0], b};
                    consume_budget();
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt >= 16'd4) begin
                        option_header_done();
                    end else if (lvl >= 1 && lvl_left[lvl] == 16'd0) begin
                        raise_error(ST_TRUNC);
                    end
                end
            end
            PH_FIX_IA, PH_FIX_ADDR, PH_DATA: begin
                take_payload_byte(b);
            end
            default: begin
            end
        endcase
        if (is_last) begin
            st = err;
            if (st == ST_OK && (phase == PH_MSG_HDR || cur_lvl > 0 || phase == PH_FIX_IA ||
                                phase == PH_FIX_ADDR || phase == PH_DATA ||
                                (phase == PH_OPT_HDR && byte_cnt != 16'd0)))
                st = ST_TRUNC;
            add_record(KIND_END, '0, '0, '0, '0, st);
            start_message();
        end
        if (beat_n > 0) beat_recs[beat_n - 1].is_last = 1'b1;
        for (int i = 0; i < beat_n; i++) parsed_records.push_back(beat_recs[i]);
    endtask

    function automatic string show_record(input t_parse_rec r);
        return {$sformatf("kind %0d type %02h tid %06h code %04h len %0d lvl %0d ",
                          r.kind, r.mtype, r.tid, r.code, r.len, r.lvl),
                $sformatf("byte %02h off %0d status %0d last %0b",
                          r.pbyte, r.off, r.status, r.is_last)};
    endfunction

    task automatic check_record();
        seen.kind    = t_kind'(i_record_kind);
        seen.mtype   = i_message_type;
        seen.tid     = i_transaction_id;
        seen.code    = i_option_code;
        seen.len     = i_option_length;
        seen.lvl     = i_nest_level;
        seen.pbyte   = i_payload_byte;
        seen.off     = i_payload_offset;
        seen.status  = t_status'(i_parse_status);
        seen.is_last = i_last_of_run;
        if (parsed_records.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("Record beat with nothing predicted: %s", show_record(seen));
        end else begin
            want = parsed_records.pop_front();
            checked++;
            if (seen !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("Record mismatch on beat %0d", checked);
                    $display("  expected %s", show_record(want));
                    $display("  actual   %s", show_record(seen));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.code_ia_na   = DEF_CODE_IA_NA;
            cfg.code_ia_pd   = DEF_CODE_IA_PD;
            cfg.code_ia_addr = DEF_CODE_IA_ADDR;
            cfg.max_len      = DEF_MAX_LEN;
            cfg.max_opts     = DEF_MAX_OPTS;
            start_message();
            parsed_records.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CODE_IA_NA:   cfg.code_ia_na   = i_cfg_data;
                    CFG_CODE_IA_PD:   cfg.code_ia_pd   = i_cfg_data;
                    CFG_CODE_IA_ADDR: cfg.code_ia_addr = i_cfg_data;
                    CFG_MAX_OPT_LEN:  cfg.max_len      = i_cfg_data;
                    CFG_MAX_OPTS:     cfg.max_opts     = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_pop && !i_empty) check_record();
            if (i_push && !i_full) parse_byte(i_data_byte, i_last_byte);
        end
        o_pending    <= parsed_records.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

/* tb/sv/dhcpv6_option_tlv_parser_tb.sv */
`timescale 1ns / 100ps
// Testbench top of the DHCPv6 option TLV parser: clock, reset, message stimulus, pops and verdict.
module dhcpv6_option_tlv_parser_tb;
    import dtp_pkg::*;

    localparam int MAX_LEVELS   = 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 80;
    localparam int SHORT_BYTES  = 40;
    localparam int NUM_SETTINGS = 6;

    typedef logic [7:0] t_bytes [$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_data_byte = '0;
    logic                 i_last_byte = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           o_record_kind;
    logic [7:0]           o_message_type;
    logic [23:0]          o_transaction_id;
    logic [15:0]          o_option_code;
    logic [15:0]          o_option_length;
    logic [1:0]           o_nest_level;
    logic [7:0]           o_payload_byte;
    logic [15:0]          o_payload_offset;
    logic [2:0]           o_parse_status;
    logic                 o_last_of_run;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   messages_sent = 0;
    int   send_calm = 0;
    int   pop_stall = 0;
    int   pop_calm = 0;
    bit   no_idle = 1'b0;
    t_cfg cfg;

    dhcpv6_option_tlv_parser #(
        .MAX_LEVELS(MAX_LEVELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .empty            (empty),
        .pop              (pop),
        .o_record_kind    (o_record_kind),
        .o_message_type   (o_message_type),
        .o_transaction_id (o_transaction_id),
        .o_option_code    (o_option_code),
        .o_option_length  (o_option_length),
        .o_nest_level     (o_nest_level),
        .o_payload_byte   (o_payload_byte),
        .o_payload_offset (o_payload_offset),
        .o_parse_status   (o_parse_status),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    dhcpv6_option_tlv_parser_checker #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_record_kind    (o_record_kind),
        .i_message_type   (o_message_type),
        .i_transaction_id (o_transaction_id),
        .i_option_code    (o_option_code),
        .i_option_length  (o_option_length),
        .i_nest_level     (o_nest_level),
        .i_payload_byte   (o_payload_byte),
        .i_payload_offset (o_payload_offset),
        .i_parse_status   (o_parse_status),
        .i_last_of_run    (o_last_of_run),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d records outstanding",
                     cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (no_idle) begin
                pop <= 1'b1;
            end else if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else if (pop_calm > 0) begin
                pop_calm--;
                pop <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                pop_stall = $urandom_range(1, 15) - 1;
                pop <= 1'b0;
            end else begin
                if ($urandom_range(0, 29) == 0) pop_calm = $urandom_range(30, 80);
                pop <= 1'b1;
            end
        end
    end

    function automatic t_bytes random_bytes(input int n);
        t_bytes q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic t_bytes join_bytes(input t_bytes a, input t_bytes b);
        t_bytes q;
        q = a;
        foreach (b[i]) q.push_back(b[i]);
        return q;
    endfunction

    function automatic t_bytes option_bytes(input logic [15:0] code, input logic [15:0] len,
                                            input t_bytes body);
        t_bytes q;
        q.push_back(code[15:8]);
        q.push_back(code[7:0]);
        q.push_back(len[15:8]);
        q.push_back(len[7:0]);
        return join_bytes(q, body);
    endfunction

    function automatic logic [15:0] pick_ia_code();
        return ($urandom_range(0, 1) == 0) ? cfg.code_ia_na : cfg.code_ia_pd;
    endfunction

    // One option, at times an IA option with one empty inner option, or malformed on purpose.
    function automatic t_bytes make_leaf();
        int          sel;
        int          n;
        logic [15:0] len;
        logic [15:0] code;
        t_bytes      body;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 4);
            return option_bytes(16'($urandom_range(0, 65535)), 16'(n), random_bytes(n));
        end else if (sel < 60) begin
            return option_bytes(pick_ia_code(), 16'(IA_FIXED_BYTES), random_bytes(IA_FIXED_BYTES));
        end else if (sel < 70) begin
            return option_bytes(cfg.code_ia_addr, 16'(ADDR_FIXED_BYTES),
                                random_bytes(ADDR_FIXED_BYTES));
        end else if (sel < 80) begin
            body = join_bytes(random_bytes(IA_FIXED_BYTES),
                              option_bytes(16'($urandom_range(0, 65535)), 16'd0, random_bytes(0)));
            return option_bytes(pick_ia_code(), 16'(IA_FIXED_BYTES + 4), body);
        end
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(0, IA_FIXED_BYTES - 1);
                return option_bytes(pick_ia_code(), 16'(n), random_bytes(n));
            end
            1: begin
                len = (cfg.max_len == 16'hFFFF) ? 16'hFFFF : cfg.max_len + 16'd1;
                code = 16'($urandom_range(0, 65535));
                return option_bytes(code, len, random_bytes(4));
            end
            2: begin
                n = $urandom_range(0, 4);
                len = 16'(n + $urandom_range(1, 3));
                return option_bytes(16'($urandom_range(0, 65535)), len, random_bytes(n));
            end
            default: return random_bytes($urandom_range(1, 3));
        endcase
    endfunction

    function automatic t_bytes make_leaf_list();
        t_bytes q;
        repeat ($urandom_range(1, 3)) q = join_bytes(q, make_leaf());
        return q;
    endfunction

    function automatic t_bytes make_ia(input t_bytes inner);
        logic [15:0] code;
        int          fixed_len;
        if ($urandom_range(0, 2) == 0) begin
            code      = cfg.code_ia_addr;
            fixed_len = ADDR_FIXED_BYTES;
        end else begin
            code      = pick_ia_code();
            fixed_len = IA_FIXED_BYTES;
        end
        return option_bytes(code, 16'(fixed_len + inner.size()),
                            join_bytes(random_bytes(fixed_len), inner));
    endfunction

    function automatic t_bytes make_mid_list();
        t_bytes q;
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 1) == 0) q = join_bytes(q, make_ia(make_leaf_list()));
            else q = join_bytes(q, make_leaf());
        end
        return q;
    endfunction

    function automatic t_bytes make_message();
        t_bytes msg;
        int     r;
        int     cut;
        msg = random_bytes(4);
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 5);
            if (r < 3) msg = join_bytes(msg, make_leaf());
            else if (r < 5) msg = join_bytes(msg, make_ia(make_leaf_list()));
            else msg = join_bytes(msg, make_ia(make_mid_list()));
        end
        case ($urandom_range(0, 9))
            7: begin
                if (msg.size() > 1) begin
                    cut = $urandom_range(1, msg.size() - 1);
                    while (msg.size() > cut) void'(msg.pop_back());
                end
            end
            8: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
            9: msg = random_bytes($urandom_range(1, 12));
            default: begin
            end
        endcase
        return msg;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic is_last);
        if (!no_idle) begin
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                send_calm = $urandom_range(20, 60);
            end else if ($urandom_range(0, 4) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_message(input t_bytes msg);
        foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
        messages_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_cfg settings_for(input int p);
        t_cfg c;
        case (p)
            1: c = '{code_ia_na: 16'd0, code_ia_pd: 16'hFFFF, code_ia_addr: 16'd5,
                     max_len: 16'hFFFF, max_opts: 8'd255};
            2: c = '{code_ia_na: 16'd9, code_ia_pd: 16'd17, code_ia_addr: 16'd9,
                     max_len: 16'd40, max_opts: 8'd1};
            3: c = '{code_ia_na: 16'($urandom_range(0, 7)), code_ia_pd: 16'($urandom_range(8, 15)),
                     code_ia_addr: 16'($urandom_range(16, 23)),
                     max_len: 16'($urandom_range(30, 300)), max_opts: 8'($urandom_range(1, 4))};
            4: c = '{code_ia_na: 16'd3, code_ia_pd: 16'd25, code_ia_addr: 16'd5,
                     max_len: 16'd0, max_opts: 8'd2};
            default: c = '{code_ia_na: 16'd3, code_ia_pd: 16'd25, code_ia_addr: 16'd5,
                           max_len: 16'd512, max_opts: 8'd64};
        endcase
        return c;
    endfunction

    task automatic apply_settings(input t_cfg c);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CODE_IA_NA;
        i_cfg_data  <= c.code_ia_na;
        @(posedge i_clk);
        i_cfg_index <= CFG_CODE_IA_PD;
        i_cfg_data  <= c.code_ia_pd;
        @(posedge i_clk);
        i_cfg_index <= CFG_CODE_IA_ADDR;
        i_cfg_data  <= c.code_ia_addr;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_OPT_LEN;
        i_cfg_data  <= c.max_len;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_OPTS;
        i_cfg_data  <= {8'h00, c.max_opts};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg = c;
    endtask

    initial begin
        int     start_bytes;
        int     budget;
        t_bytes msg;
        cfg = settings_for(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero-length opaque option after an all-ones header ends cleanly.
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_message(msg);
        msg = '{8'h00};
        send_message(msg);
        msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'hFF, 8'hFF};
        send_message(msg);
        msg = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h03, 8'h00, 8'h0B};
        send_message(msg);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p > 0) apply_settings(settings_for(p));
            if (p == NUM_SETTINGS - 1) no_idle = 1'b1;
            budget = (p == 4) ? SHORT_BYTES : PHASE_BYTES;
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < budget) send_message(make_message());
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d messages and %0d bytes pushed, %0d records checked.",
                 messages_sent, bytes_sent, checked);
        $display("Summary: %0d register settings, random idling on both sides except the last.",
                 NUM_SETTINGS);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
